// ===== design/sorted_record_table_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_record_table_defines
// Assertion macros for the sorted record table checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECORD_TABLE_DEFINES_SVH
`define SORTED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication
`define SRT_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sorted_record_table: same-cycle check failed");

// next-cycle implication
`define SRT_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sorted_record_table: next-cycle check failed");

`endif

// ===== design/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Request, status and sequencer state codes of the sorted record table.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_FIND_ID   = 2'd1,
    REQ_DELETE    = 2'd2,
    REQ_FIND_NAME = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_t;

endpackage

`default_nettype wire

// ===== design/srt_in_if.sv =====
// ----------------------------------------------------------------------------
// srt_in_if
// Request channel: one request word per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] record_id;
  logic [63:0] record_name;
  logic [7:0]  record_age;
  logic [7:0]  record_sex;
  logic [5:0]  position;
  logic        from_start;

  modport source (
    output valid, req_type, record_id, record_name, record_age, record_sex,
           position, from_start,
    input  ready
  );

  modport sink (
    input  valid, req_type, record_id, record_name, record_age, record_sex,
           position, from_start,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/srt_out_if.sv =====
// ----------------------------------------------------------------------------
// srt_out_if
// Result channel: one result word per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  found_index;
  logic [63:0] found_id;
  logic [63:0] found_name;
  logic [7:0]  found_age;
  logic [7:0]  found_sex;
  logic [6:0]  entry_count;

  modport source (
    output valid, status, found_index, found_id, found_name, found_age,
           found_sex, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, found_index, found_id, found_name, found_age,
           found_sex, entry_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/srt_ram.sv =====
// ----------------------------------------------------------------------------
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/sorted_record_table.sv =====
// Scan: one read per entry through the record RAM read port, over at most the
//   entries held (CAPACITY worst case).
// A find by ID stops early at a hit (or a larger ID), a find by name at a hit.
// One request at a time; the next is taken while a result waits.
// Reset: synchronous, clears the entry count and control; the record RAM is
//   not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// sorted_record_table
// Table of records kept sorted by ID in one RAM, with insert, find-by-ID,
// delete-at-position and find-next-by-name done as a single RAM pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_record_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BYTES  = 8,
  parameter int NAME_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_ch,
  srt_out_if.source out_ch
);
  import srt_pkg::*;

  localparam int KEY_W  = 8 * KEY_BYTES;
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int REC_W  = KEY_W + NAME_W + 16;
  localparam int AW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int PW     = (CW > 7) ? CW : 7;

  // keep nbytes bytes, clear all bytes after the first NUL
  function automatic logic [63:0] canon(input logic [63:0] v, input int nbytes);
    logic [63:0] r;
    logic        seen;
    r    = '0;
    seen = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (i < nbytes) begin
        if (!seen) begin
          r[8*i +: 8] = v[8*i +: 8];
        end
        if (v[8*i +: 8] == 8'h00) begin
          seen = 1'b1;
        end
      end
    end
    return r;
  endfunction

  state_t            state_r, state_nxt;
  req_t              op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [NAME_W-1:0] nm_r, nm_nxt;
  logic [7:0]        age_r, age_nxt;
  logic [7:0]        sex_r, sex_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [PW-1:0]     rd_r, rd_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              dv_r, dv_nxt;
  logic [AW-1:0]     didx_r, didx_nxt;
  logic              stop_r, stop_nxt;
  logic              ins_r, ins_nxt;
  logic              fail_r, fail_nxt;
  status_t           fstat_r, fstat_nxt;
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     hidx_r, hidx_nxt;
  logic [REC_W-1:0]  hrec_r, hrec_nxt;
  logic [REC_W-1:0]  carry_r, carry_nxt;

  logic              ov_r, ov_nxt;
  status_t           o_status_r, o_status_nxt;
  logic [5:0]        o_idx_r, o_idx_nxt;
  logic [63:0]       o_id_r, o_id_nxt;
  logic [63:0]       o_nm_r, o_nm_nxt;
  logic [7:0]        o_age_r, o_age_nxt;
  logic [7:0]        o_sex_r, o_sex_nxt;
  logic [6:0]        o_cnt_r, o_cnt_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [REC_W-1:0]  ram_wdata, ram_rdata;

  logic              accept, out_free, scan_done;
  logic [63:0]       key_full, nm_full;
  logic [PW-1:0]     pos_ext, cnt_ext, nm_start;
  logic [KEY_W-1:0]  r_id;
  logic [NAME_W-1:0] r_nm;
  logic [REC_W-1:0]  new_rec, res_rec;
  logic [AW-1:0]     res_idx;
  logic              res_ok;
  status_t           res_status;
  logic [CW-1:0]     cnt_fin;

  srt_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;

  assign key_full = canon(in_ch.record_id, KEY_BYTES);
  assign nm_full  = canon(in_ch.record_name, NAME_BYTES);
  assign pos_ext  = PW'(in_ch.position);
  assign cnt_ext  = PW'(cnt_r);
  assign nm_start = in_ch.from_start ? '0 : pos_ext + PW'(1);

  assign r_id    = ram_rdata[REC_W-1 -: KEY_W];
  assign r_nm    = ram_rdata[REC_W-KEY_W-1 -: NAME_W];
  assign new_rec = {key_r, nm_r, age_r, sex_r};

  assign scan_done = !dv_r && (stop_r || (rd_r >= PW'(end_r)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done || fail_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // finishing result
  always_comb begin
    res_ok     = 1'b0;
    res_status = fstat_r;
    res_idx    = hidx_r;
    res_rec    = hrec_r;
    cnt_fin    = cnt_r;
    if (!fail_r) begin
      case (op_r)
        REQ_INSERT: begin
          res_ok  = 1'b1;
          res_idx = ins_r ? hidx_r : end_r[AW-1:0];
          res_rec = new_rec;
          cnt_fin = cnt_r + CW'(1);
        end
        REQ_DELETE: begin
          res_ok  = 1'b1;
          cnt_fin = cnt_r - CW'(1);
        end
        default: begin
          res_ok = hit_r;
        end
      endcase
      res_status = res_ok ? ST_OK : ST_NOT_FOUND;
    end
  end

  // datapath and RAM control
  always_comb begin
    op_nxt    = op_r;
    key_nxt   = key_r;
    nm_nxt    = nm_r;
    age_nxt   = age_r;
    sex_nxt   = sex_r;
    pos_nxt   = pos_r;
    rd_nxt    = rd_r;
    end_nxt   = end_r;
    cnt_nxt   = cnt_r;
    dv_nxt    = 1'b0;
    didx_nxt  = didx_r;
    stop_nxt  = stop_r;
    ins_nxt   = ins_r;
    fail_nxt  = fail_r;
    fstat_nxt = fstat_r;
    hit_nxt   = hit_r;
    hidx_nxt  = hidx_r;
    hrec_nxt  = hrec_r;
    carry_nxt = carry_r;

    ov_nxt       = ov_r && !out_ch.ready;
    o_status_nxt = o_status_r;
    o_idx_nxt    = o_idx_r;
    o_id_nxt     = o_id_r;
    o_nm_nxt     = o_nm_r;
    o_age_nxt    = o_age_r;
    o_sex_nxt    = o_sex_r;
    o_cnt_nxt    = o_cnt_r;

    ram_we    = 1'b0;
    ram_waddr = didx_r;
    ram_wdata = carry_r;
    ram_re    = 1'b0;
    ram_raddr = rd_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = req_t'(in_ch.req_type);
          key_nxt   = key_full[KEY_W-1:0];
          nm_nxt    = nm_full[NAME_W-1:0];
          age_nxt   = in_ch.record_age;
          sex_nxt   = in_ch.record_sex;
          pos_nxt   = in_ch.position;
          end_nxt   = cnt_r;
          stop_nxt  = 1'b0;
          ins_nxt   = 1'b0;
          hit_nxt   = 1'b0;
          fail_nxt  = 1'b0;
          fstat_nxt = ST_NOT_FOUND;
          rd_nxt    = '0;
          case (req_t'(in_ch.req_type))
            REQ_INSERT: begin
              fail_nxt  = (cnt_r >= CW'(CAPACITY));
              fstat_nxt = ST_FULL;
            end
            REQ_DELETE: begin
              fail_nxt  = (pos_ext >= cnt_ext);
              fstat_nxt = ST_RANGE;
              rd_nxt    = pos_ext;
            end
            REQ_FIND_NAME: begin
              fail_nxt  = (nm_start >= cnt_ext);
              rd_nxt    = nm_start;
            end
            default: begin
              fail_nxt = 1'b0;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!fail_r && !stop_r && (rd_r < PW'(end_r))) begin
          ram_re   = 1'b1;
          dv_nxt   = 1'b1;
          didx_nxt = rd_r[AW-1:0];
          rd_nxt   = rd_r + PW'(1);
        end
        if (dv_r && !stop_r) begin
          case (op_r)
            REQ_INSERT: begin
              if (!ins_r && (r_id > key_r)) begin
                ram_we    = 1'b1;
                ram_wdata = new_rec;
                carry_nxt = ram_rdata;
                ins_nxt   = 1'b1;
                hidx_nxt  = didx_r;
              end else if (ins_r) begin
                ram_we    = 1'b1;
                carry_nxt = ram_rdata;
              end
            end
            REQ_FIND_ID: begin
              if (r_id == key_r) begin
                hit_nxt  = 1'b1;
                hidx_nxt = didx_r;
                hrec_nxt = ram_rdata;
                stop_nxt = 1'b1;
              end else if (r_id > key_r) begin
                stop_nxt = 1'b1;
              end
            end
            REQ_DELETE: begin
              if (PW'(didx_r) == PW'(pos_r)) begin
                hidx_nxt = didx_r;
                hrec_nxt = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = didx_r - AW'(1);
                ram_wdata = ram_rdata;
              end
            end
            default: begin
              if (r_nm == nm_r) begin
                hit_nxt  = 1'b1;
                hidx_nxt = didx_r;
                hrec_nxt = ram_rdata;
                stop_nxt = 1'b1;
              end
            end
          endcase
        end
      end

      S_FIN: begin
        // tail write of an insert; repeating it while stalled is harmless
        if (!fail_r && (op_r == REQ_INSERT)) begin
          ram_we    = 1'b1;
          ram_waddr = end_r[AW-1:0];
          ram_wdata = ins_r ? carry_r : new_rec;
        end
        if (out_free) begin
          cnt_nxt      = cnt_fin;
          ov_nxt       = 1'b1;
          o_status_nxt = res_status;
          o_cnt_nxt    = 7'(cnt_fin);
          if (res_ok) begin
            o_idx_nxt = 6'(res_idx);
            o_id_nxt  = 64'(res_rec[REC_W-1 -: KEY_W]);
            o_nm_nxt  = 64'(res_rec[REC_W-KEY_W-1 -: NAME_W]);
            o_age_nxt = res_rec[15:8];
            o_sex_nxt = res_rec[7:0];
          end else begin
            o_idx_nxt = '0;
            o_id_nxt  = '0;
            o_nm_nxt  = '0;
            o_age_nxt = '0;
            o_sex_nxt = '0;
          end
        end
      end

      default: begin
        dv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
      stop_r  <= 1'b0;
      ins_r   <= 1'b0;
      fail_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
      ov_r    <= ov_nxt;
      stop_r  <= stop_nxt;
      ins_r   <= ins_nxt;
      fail_r  <= fail_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    nm_r       <= nm_nxt;
    age_r      <= age_nxt;
    sex_r      <= sex_nxt;
    pos_r      <= pos_nxt;
    rd_r       <= rd_nxt;
    end_r      <= end_nxt;
    didx_r     <= didx_nxt;
    fstat_r    <= fstat_nxt;
    hidx_r     <= hidx_nxt;
    hrec_r     <= hrec_nxt;
    carry_r    <= carry_nxt;
    o_status_r <= o_status_nxt;
    o_idx_r    <= o_idx_nxt;
    o_id_r     <= o_id_nxt;
    o_nm_r     <= o_nm_nxt;
    o_age_r    <= o_age_nxt;
    o_sex_r    <= o_sex_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = o_status_r;
  assign out_ch.found_index = o_idx_r;
  assign out_ch.found_id    = o_id_r;
  assign out_ch.found_name  = o_nm_r;
  assign out_ch.found_age   = o_age_r;
  assign out_ch.found_sex   = o_sex_r;
  assign out_ch.entry_count = o_cnt_r;

endmodule

`default_nettype wire

// ===== design/srt_checker.sv =====
// ----------------------------------------------------------------------------
// srt_checker
// Port-level checks of the sorted record table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_record_table_defines.svh"

module srt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [5:0]  out_found_index,
  input wire logic [63:0] out_found_id,
  input wire logic [63:0] out_found_name,
  input wire logic [7:0]  out_found_age,
  input wire logic [7:0]  out_found_sex
);
  import srt_pkg::*;

  logic rec_zero;

  assign rec_zero = (out_found_index == 6'd0) && (out_found_id == 64'd0) &&
                    (out_found_name == 64'd0) && (out_found_age == 8'd0) &&
                    (out_found_sex == 8'd0);

  // stalled result keeps valid and status
  `SRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SRT_ASSERT_NXT(a_status_hold, clk, rst_n, out_valid && !out_ready, $stable(out_status))

  // one request at a time
  `SRT_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // failed requests carry an all-zero record
  `SRT_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK), rec_zero)

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_index (out_ch.found_index),
  .out_found_id    (out_ch.found_id),
  .out_found_name  (out_ch.found_name),
  .out_found_age   (out_ch.found_age),
  .out_found_sex   (out_ch.found_sex)
);

`default_nettype wire
